// ===== hdl/bsab_pkg.sv =====
// bsab_pkg: shared types, constants and helpers of the brush stamp alpha blender
// no dependencies; used by the channel interfaces and by brush_stamp_alpha_blend
`default_nettype none

package bsab_pkg;

    // brush geometry
    localparam int MAX_RADIUS = 63;
    localparam int FRAC_BITS  = 4;

    // field widths
    localparam int OFS_W    = 12;
    localparam int CHAN_W   = 8;
    localparam int RADIUS_W = 10;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_BRUSH_RED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRUSH_GREEN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BRUSH_BLUE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BRUSH_ALPHA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_Q4   = 3'd4;

    // register reset values
    localparam logic [CHAN_W-1:0]   BRUSH_ALPHA_RST = 8'd255;
    localparam logic [RADIUS_W-1:0] RADIUS_RST      = 10'd16;

    typedef struct packed {
        logic signed [OFS_W-1:0] offset_x_q4;
        logic signed [OFS_W-1:0] offset_y_q4;
        logic [CHAN_W-1:0]       back_red;
        logic [CHAN_W-1:0]       back_green;
        logic [CHAN_W-1:0]       back_blue;
        logic [CHAN_W-1:0]       back_alpha;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              touched;
    } out_item_t;

    // rgba quad, red in element 0
    typedef logic [3:0][CHAN_W-1:0] rgba_t;

    // floor(x / 255), exact for x up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] t;
        t = (2*CHAN_W+1)'(x) + (2*CHAN_W+1)'(x[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
        return t[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bsab_if.sv =====
// bsab_in_if / bsab_out_if: valid-ready channels for pixel items in and out
// depends on bsab_pkg for the item types
`default_nettype none

interface bsab_in_if;
    import bsab_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsab_out_if;
    import bsab_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/brush_stamp_alpha_blend.sv =====
// brush_stamp_alpha_blend: antialiased disc brush blended onto rgba8 frame pixels
// depends on bsab_pkg and on the bsab_in_if / bsab_out_if channel interfaces
`default_nettype none

// One frame pixel item goes in and one blended pixel item comes out per cycle
// while the output takes items. Its stages: squares, radicand, square root (one
// result bit per stage), excess, coverage, product, weight, blend products, output.
// Throughput is one item per clock: the whole pipeline moves whenever its last
// stage is empty or the output side takes the item, so pix_in.ready only drops
// while a finished item waits at the output. The distance is floor(256 * d) from an
// exact integer root, coverage is 255 * (1 - clamp(d - radius, 0, 1)) truncated,
// and brush_alpha scales it into the foreground weight. A full weight writes the
// brush colour with brush_alpha as alpha; zero coverage passes the pixel with
// touched low. The radius saturates at MAX_RADIUS pixels. Registers sit on an apb
// port at byte offsets 0, 4, 8, 12, 16 (red, green, blue, alpha, radius); they
// should only be written while no item is in flight.
module brush_stamp_alpha_blend (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bsab_in_if.sink                              pix_in,
    bsab_out_if.source                           pix_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bsab_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bsab_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bsab_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import bsab_pkg::*;

    // squared distance and root widths
    localparam int SQ_W       = 2*OFS_W - 1;              // one square
    localparam int SUM_W      = SQ_W + 1;                 // sum of two squares
    localparam int ROOT_SHIFT = 16 - 2*FRAC_BITS;         // to 16 fraction bits
    localparam int RAD_W      = SUM_W + ROOT_SHIFT;       // radicand
    localparam int ROOT_W     = RAD_W / 2;                // distance in q8
    localparam int REM_W      = ROOT_W + 2;
    localparam int R8_W       = RADIUS_W + 8 - FRAC_BITS;
    localparam int CMP_W      = ((ROOT_W > R8_W) ? ROOT_W : R8_W) + 1;
    localparam int E_W        = 9;                        // excess 0..256
    localparam int PROD_W     = 2*CHAN_W;

    localparam logic [RADIUS_W-1:0] RMAX = RADIUS_W'(MAX_RADIUS << FRAC_BITS);
    localparam logic [E_W-1:0]      E_FULL = 9'd256;

    // pipeline stage indexes
    localparam int ST_SQ   = 0;
    localparam int ST_ROOT = ST_SQ + 1 + ROOT_W;
    localparam int ST_E    = ST_ROOT + 1;
    localparam int ST_COV  = ST_E + 1;
    localparam int ST_CA   = ST_COV + 1;
    localparam int ST_FG   = ST_CA + 1;
    localparam int ST_PR   = ST_FG + 1;
    localparam int ST_OUT  = ST_PR + 1;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [CHAN_W-1:0]    brush_red_reg;
    logic [CHAN_W-1:0]    brush_green_reg;
    logic [CHAN_W-1:0]    brush_blue_reg;
    logic [CHAN_W-1:0]    brush_alpha_reg;
    logic [RADIUS_W-1:0]  radius_q4_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_red_reg   <= '0;
            brush_green_reg <= '0;
            brush_blue_reg  <= '0;
            brush_alpha_reg <= BRUSH_ALPHA_RST;
            radius_q4_reg   <= RADIUS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BRUSH_RED:   brush_red_reg   <= pwdata[CHAN_W-1:0];
                REG_BRUSH_GREEN: brush_green_reg <= pwdata[CHAN_W-1:0];
                REG_BRUSH_BLUE:  brush_blue_reg  <= pwdata[CHAN_W-1:0];
                REG_BRUSH_ALPHA: brush_alpha_reg <= pwdata[CHAN_W-1:0];
                REG_RADIUS_Q4:   radius_q4_reg   <= pwdata[RADIUS_W-1:0];
                default:         ; // unmapped offsets drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BRUSH_RED:   prdata = APB_DATA_W'(brush_red_reg);
            REG_BRUSH_GREEN: prdata = APB_DATA_W'(brush_green_reg);
            REG_BRUSH_BLUE:  prdata = APB_DATA_W'(brush_blue_reg);
            REG_BRUSH_ALPHA: prdata = APB_DATA_W'(brush_alpha_reg);
            REG_RADIUS_Q4:   prdata = APB_DATA_W'(radius_q4_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // pipeline control: one enable for every stage
    // ---------------------------------------------------------------------
    logic [ST_OUT:0] valid_reg;
    logic            en;

    assign en           = !valid_reg[ST_OUT] || pix_out.ready;
    assign pix_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[ST_OUT-1:0], pix_in.valid};
    end

    // background pixel travels alongside the math
    rgba_t back_reg [0:ST_OUT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            back_reg[0] <= {pix_in.data.back_alpha, pix_in.data.back_blue,
                            pix_in.data.back_green, pix_in.data.back_red};
            for (int k = 1; k < ST_OUT; k++)
                back_reg[k] <= back_reg[k-1];
        end
    end

    // ---------------------------------------------------------------------
    // stage 0: squares of the offsets
    // ---------------------------------------------------------------------
    logic signed [2*OFS_W-1:0] prod_x;
    logic signed [2*OFS_W-1:0] prod_y;
    logic [SQ_W-1:0]           sq_x_reg;
    logic [SQ_W-1:0]           sq_y_reg;

    assign prod_x = pix_in.data.offset_x_q4 * pix_in.data.offset_x_q4;
    assign prod_y = pix_in.data.offset_y_q4 * pix_in.data.offset_y_q4;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg <= prod_x[SQ_W-1:0];
            sq_y_reg <= prod_y[SQ_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // square root: one result bit per stage, remainder form
    // ---------------------------------------------------------------------
    logic [RAD_W-1:0]  sq_rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];
    logic [SUM_W-1:0]  dist_sum;

    assign dist_sum = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rad_reg[0]  <= RAD_W'(dist_sum) << ROOT_SHIFT;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar gi = 0; gi < ROOT_W; gi++)
    begin : g_sqrt
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] test;

        assign trial = {sq_rem_reg[gi], sq_rad_reg[gi][RAD_W-1 -: 2]};
        assign test  = (REM_W+2)'({sq_root_reg[gi], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rad_reg[gi+1] <= sq_rad_reg[gi] << 2;
                if (trial >= test)
                begin
                    sq_rem_reg[gi+1]  <= REM_W'(trial - test);
                    sq_root_reg[gi+1] <= {sq_root_reg[gi][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[gi+1]  <= trial[REM_W-1:0];
                    sq_root_reg[gi+1] <= {sq_root_reg[gi][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // excess distance beyond the radius, clamped to one pixel
    // ---------------------------------------------------------------------
    logic [RADIUS_W-1:0] rad_sat;
    logic [CMP_W-1:0]    d8_ext;
    logic [CMP_W-1:0]    r8_ext;
    logic [CMP_W-1:0]    excess;
    logic [E_W-1:0]      e_next;
    logic [E_W-1:0]      e_reg;

    assign rad_sat = (radius_q4_reg > RMAX) ? RMAX : radius_q4_reg;
    assign d8_ext  = CMP_W'(sq_root_reg[ROOT_W]);
    assign r8_ext  = CMP_W'(rad_sat) << (8 - FRAC_BITS);
    assign excess  = d8_ext - r8_ext;

    always_comb
    begin
        priority if (d8_ext <= r8_ext)
            e_next = '0;
        else if (excess > CMP_W'(E_FULL))
            e_next = E_FULL;
        else
            e_next = excess[E_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            e_reg <= e_next;
    end

    // ---------------------------------------------------------------------
    // coverage = (255 * (256 - e)) >> 8
    // ---------------------------------------------------------------------
    logic [E_W-1:0]      in_frac;
    logic [E_W+CHAN_W-1:0] cov_full;
    logic [CHAN_W-1:0]   cov_reg;
    logic                hit_cov_reg;

    assign in_frac  = E_FULL - e_reg;
    assign cov_full = ((E_W+CHAN_W)'(in_frac) << CHAN_W) - (E_W+CHAN_W)'(in_frac);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cov_reg     <= cov_full[E_W+CHAN_W-2:CHAN_W];
            hit_cov_reg <= (cov_full[E_W+CHAN_W-2:CHAN_W] != '0);
        end
    end

    // ---------------------------------------------------------------------
    // foreground weight = cov * alpha / 255
    // ---------------------------------------------------------------------
    logic [PROD_W-1:0] ca_reg;
    logic              hit_ca_reg;
    logic [CHAN_W-1:0] fg_reg;
    logic              hit_fg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg     <= PROD_W'(cov_reg) * PROD_W'(brush_alpha_reg);
            hit_ca_reg <= hit_cov_reg;
            fg_reg     <= div255(ca_reg);
            hit_fg_reg <= hit_ca_reg;
        end
    end

    // ---------------------------------------------------------------------
    // blend products, four channels
    // ---------------------------------------------------------------------
    rgba_t             fore;
    logic [CHAN_W-1:0] inv_fg;
    logic [PROD_W-1:0] fore_prod_reg [0:3];
    logic [PROD_W-1:0] back_prod_reg [0:3];
    logic              full_pr_reg;
    logic              hit_pr_reg;

    assign fore   = {brush_alpha_reg, brush_blue_reg, brush_green_reg, brush_red_reg};
    assign inv_fg = 8'd255 - fg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                fore_prod_reg[c] <= PROD_W'(fore[c]) * PROD_W'(fg_reg);
                back_prod_reg[c] <= PROD_W'(back_reg[ST_FG][c]) * PROD_W'(inv_fg);
            end
            full_pr_reg <= (fg_reg == 8'd255);
            hit_pr_reg  <= hit_fg_reg;
        end
    end

    // ---------------------------------------------------------------------
    // output register: divide, then choose pass, brush or blend
    // ---------------------------------------------------------------------
    rgba_t             mix;
    rgba_t             pick;
    logic [PROD_W:0]   mix_sum [0:3];
    out_item_t         out_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            // sum stays at or below 255 * 255
            mix_sum[c] = (PROD_W+1)'(fore_prod_reg[c]) + (PROD_W+1)'(back_prod_reg[c]);
            mix[c]     = div255(mix_sum[c][PROD_W-1:0]);
        end
        priority if (!hit_pr_reg)
            pick = back_reg[ST_PR];
        else if (full_pr_reg)
            pick = fore;
        else
            pick = mix;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.out_red   <= pick[0];
            out_reg.out_green <= pick[1];
            out_reg.out_blue  <= pick[2];
            out_reg.out_alpha <= pick[3];
            out_reg.touched   <= hit_pr_reg;
        end
    end

    assign pix_out.valid = valid_reg[ST_OUT];
    assign pix_out.data  = out_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------

    // zero coverage must give zero weight
    a_no_fg_without_cov: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_FG] && !hit_fg_reg |-> fg_reg == '0)
        else $error("foreground weight without coverage");

    // a pixel inside the radius is fully covered
    a_inside_full_cov: assert property (@(posedge clk) disable iff (!rst_n)
        en && valid_reg[ST_E] && e_reg == '0 |=> cov_reg == 8'd255)
        else $error("inside pixel lost coverage");

    // a stalled result keeps its slot and its touched flag
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_OUT] && !pix_out.ready |=> valid_reg[ST_OUT] && $stable(out_reg))
        else $error("stalled output changed");

    // a bubble at the output never blocks the input side
    a_bubble_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[ST_OUT] |-> pix_in.ready)
        else $error("input stalled behind an empty output");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for brush_stamp_alpha_blend (disc brush over rgba8 pixels)
// depends on bsab_pkg, bsab_in_if / bsab_out_if and the block itself; nothing else

module testbench;
    import bsab_pkg::*;

    // bench knobs
    localparam int IDLE_PCT    = 20;     // chance per cycle that a side idles
    localparam int STALL_LIMIT = 4000;   // cycles without any accepted item before giving up
    localparam int HOLD_LEN    = 160;    // long back-pressure stretch on the result side
    localparam int HOLD_AT_A   = 500;    // result counts that start a long hold
    localparam int HOLD_AT_B   = 1400;
    localparam int DRAIN_PAD   = 40;     // margin before the final verdict
    localparam int PRINT_CAP   = 30;     // stop printing mismatches after this many

    // radius clamp and the q8 distance shifts of the datapath
    localparam int RADIUS_SAT = MAX_RADIUS << FRAC_BITS;
    localparam int SQ_SHIFT   = 16 - 2 * FRAC_BITS;
    localparam int RAD_SHIFT  = 8 - FRAC_BITS;

    logic clk;
    logic rst_n;

    // apb configuration port
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bsab_in_if  pix_in_ch ();
    bsab_out_if pix_out_ch ();

    brush_stamp_alpha_blend u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch.sink),
        .pix_out (pix_out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bench copy of the brush registers, kept in step with every apb write
    logic [CHAN_W-1:0]   brush_r;
    logic [CHAN_W-1:0]   brush_g;
    logic [CHAN_W-1:0]   brush_b;
    logic [CHAN_W-1:0]   brush_a;
    logic [RADIUS_W-1:0] brush_rad;

    in_item_t  pixel_feed_q[$];    // pixels waiting to be offered to the block
    out_item_t blend_due_q[$];     // predicted blended pixels, oldest first

    int  pix_sent;                 // pixels queued for sending
    int  pix_back;                 // blended pixels taken from the block
    int  err_count;
    int  stall_cycles;
    int  hold_left;
    bit  quiet;                    // set for a phase with no idling on either side
    out_item_t blend_want;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // largest r with r*r <= v, one result bit at a time from the top
    function automatic int unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return int'(r);
    endfunction

    // floor((fore * fg + back * (255 - fg)) / 255)
    function automatic logic [CHAN_W-1:0] mix_chan(input int unsigned fore,
                                                   input int unsigned back,
                                                   input int unsigned fg);
        return CHAN_W'((fore * fg + back * (255 - fg)) / 255);
    endfunction

    // expected written-back pixel for one frame pixel under the current brush
    function automatic out_item_t blend_pixel(input in_item_t px);
        int              dx;
        int              dy;
        longint unsigned sq;
        int unsigned     dist8;
        int unsigned     rad;
        int unsigned     rim8;
        int unsigned     excess;
        int unsigned     cov;
        int unsigned     fg;
        out_item_t       o;
        dx = int'($signed(px.offset_x_q4));
        dy = int'($signed(px.offset_y_q4));
        sq = longint'(dx * dx + dy * dy);
        // distance in q8, truncated
        dist8 = floor_root(sq << SQ_SHIFT);
        rad = brush_rad;
        if (rad > RADIUS_SAT)
            rad = RADIUS_SAT;
        rim8 = rad << RAD_SHIFT;
        // soft edge one pixel wide beyond the radius
        excess = 0;
        if (dist8 > rim8)
            excess = (dist8 - rim8 > 256) ? 256 : dist8 - rim8;
        cov = (255 * (256 - excess)) >> 8;
        if (cov == 0)
        begin
            // outside the disc: pixel passes untouched
            o.out_red   = px.back_red;
            o.out_green = px.back_green;
            o.out_blue  = px.back_blue;
            o.out_alpha = px.back_alpha;
            o.touched   = 1'b0;
            return o;
        end
        fg = (cov * brush_a) / 255;
        if (fg >= 255)
        begin
            o.out_red   = brush_r;
            o.out_green = brush_g;
            o.out_blue  = brush_b;
            o.out_alpha = brush_a;
        end
        else
        begin
            o.out_red   = mix_chan(brush_r, px.back_red, fg);
            o.out_green = mix_chan(brush_g, px.back_green, fg);
            o.out_blue  = mix_chan(brush_b, px.back_blue, fg);
            o.out_alpha = mix_chan(brush_a, px.back_alpha, fg);
        end
        o.touched = 1'b1;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t make_pixel(input int dx, input int dy,
                                            input logic [31:0] rgba);
        in_item_t px;
        px.offset_x_q4 = OFS_W'(dx);
        px.offset_y_q4 = OFS_W'(dy);
        px.back_red    = rgba[31:24];
        px.back_green  = rgba[23:16];
        px.back_blue   = rgba[15:8];
        px.back_alpha  = rgba[7:0];
        return px;
    endfunction

    // offsets at the corners of the 12-bit range and around the origin
    function automatic int corner_ofs(input int k);
        case (k)
            0: return 0;
            1: return 1;
            2: return -1;
            3: return 1024;
            4: return -1024;
            5: return 2047;
            default: return -2048;
        endcase
    endfunction

    // random pixel; 45 percent aim at the antialiased rim of the current brush
    function automatic in_item_t random_pixel();
        in_item_t px;
        int       mode;
        int       reff;
        int       target;
        int       ax;
        int       ay;
        int       span;
        mode = $urandom_range(99);
        reff = (brush_rad > RADIUS_SAT) ? RADIUS_SAT : int'(brush_rad);
        if (mode < 45)
        begin
            // a point close to the radius, from a quarter pixel inside to a quarter pixel past the fringe
            target = reff + $urandom_range(24) - 4;
            if (target < 0)
                target = 0;
            ax = $urandom_range(target);
            ay = floor_root(longint'(target * target - ax * ax)) + $urandom_range(1);
            if ($urandom_range(1))
                ax = -ax;
            if ($urandom_range(1))
                ay = -ay;
            if ($urandom_range(1))
                px = make_pixel(ax, ay, $urandom);
            else
                px = make_pixel(ay, ax, $urandom);
        end
        else if (mode < 75)
        begin
            // box around the disc
            span = 2 * reff + 32;
            if (span > 2047)
                span = 2047;
            px = make_pixel(int'($urandom_range(2 * span)) - span,
                            int'($urandom_range(2 * span)) - span, $urandom);
        end
        else if (mode < 92)
        begin
            // anywhere in the 12-bit offset range
            px = make_pixel($urandom, $urandom, $urandom);
        end
        else
        begin
            px = make_pixel(corner_ofs($urandom_range(6)), corner_ofs($urandom_range(6)),
                            $urandom);
        end
        return px;
    endfunction

    task automatic feed(input in_item_t px);
        pixel_feed_q.push_back(px);
        pix_sent++;
    endtask

    // every queued pixel has come back
    task automatic wait_drained();
        while (pix_back != pix_sent)
            @(posedge clk);
    endtask

    task automatic run_random(input int n, input bit no_idle);
        quiet = no_idle;
        repeat (n)
            feed(random_pixel());
        wait_drained();
        quiet = 1'b0;
    endtask

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // apb register access
    // ------------------------------------------------------------------

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the register took the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BRUSH_RED:   brush_r = value[CHAN_W-1:0];
            REG_BRUSH_GREEN: brush_g = value[CHAN_W-1:0];
            REG_BRUSH_BLUE:  brush_b = value[CHAN_W-1:0];
            REG_BRUSH_ALPHA: brush_a = value[CHAN_W-1:0];
            REG_RADIUS_Q4:   brush_rad = value[RADIUS_W-1:0];
            default: ;       // beyond the register list, dropped
        endcase
    endtask

    task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] want;
        case (idx)
            REG_BRUSH_RED:   want = APB_DATA_W'(brush_r);
            REG_BRUSH_GREEN: want = APB_DATA_W'(brush_g);
            REG_BRUSH_BLUE:  want = APB_DATA_W'(brush_b);
            REG_BRUSH_ALPHA: want = APB_DATA_W'(brush_a);
            default:         want = APB_DATA_W'(brush_rad);
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        // read data is valid through the access cycle
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            flag_mismatch($sformatf("register %0d read %0h want %0h", idx, got, want));
    endtask

    // full brush setup followed by a read-back of all five registers
    task automatic set_brush(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b,
                             input logic [31:0] a, input logic [31:0] rad);
        reg_write(REG_BRUSH_RED, r);
        reg_write(REG_BRUSH_GREEN, g);
        reg_write(REG_BRUSH_BLUE, b);
        reg_write(REG_BRUSH_ALPHA, a);
        reg_write(REG_RADIUS_Q4, rad);
        for (int i = REG_BRUSH_RED; i <= REG_RADIUS_Q4; i++)
            reg_read_check(REG_IDX_W'(i));
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // pixel driver: offers queued pixels, predicts each one as it is taken
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in_ch.valid <= 1'b0;
            pix_in_ch.data  <= '0;
        end
        else
        begin
            // registers never change while pixels are in flight, so predict on acceptance
            if (pix_in_ch.valid && pix_in_ch.ready)
                blend_due_q.push_back(blend_pixel(pix_in_ch.data));
            if (!pix_in_ch.valid || pix_in_ch.ready)
            begin
                if (pixel_feed_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    pix_in_ch.valid <= 1'b1;
                    pix_in_ch.data  <= pixel_feed_q.pop_front();
                end
                else
                begin
                    pix_in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, two long holds, field compare
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_out_ch.ready <= 1'b0;
            hold_left        <= 0;
        end
        else
        begin
            if (pix_out_ch.valid && pix_out_ch.ready)
            begin
                pix_back++;
                if (blend_due_q.size() == 0)
                begin
                    flag_mismatch("blended pixel with nothing expected");
                end
                else
                begin
                    blend_want = blend_due_q.pop_front();
                    if (pix_out_ch.data.out_red !== blend_want.out_red)
                        flag_mismatch($sformatf("out_red %0d want %0d",
                                                pix_out_ch.data.out_red, blend_want.out_red));
                    if (pix_out_ch.data.out_green !== blend_want.out_green)
                        flag_mismatch($sformatf("out_green %0d want %0d",
                                                pix_out_ch.data.out_green, blend_want.out_green));
                    if (pix_out_ch.data.out_blue !== blend_want.out_blue)
                        flag_mismatch($sformatf("out_blue %0d want %0d",
                                                pix_out_ch.data.out_blue, blend_want.out_blue));
                    if (pix_out_ch.data.out_alpha !== blend_want.out_alpha)
                        flag_mismatch($sformatf("out_alpha %0d want %0d",
                                                pix_out_ch.data.out_alpha, blend_want.out_alpha));
                    if (pix_out_ch.data.touched !== blend_want.touched)
                        flag_mismatch($sformatf("touched %0b want %0b",
                                                pix_out_ch.data.touched, blend_want.touched));
                end
            end
            // long hold: the pipeline fills and the input side has to stall
            if (hold_left != 0)
            begin
                hold_left        <= hold_left - 1;
                pix_out_ch.ready <= 1'b0;
            end
            else if (pix_out_ch.valid && pix_out_ch.ready &&
                     (pix_back == HOLD_AT_A || pix_back == HOLD_AT_B))
            begin
                hold_left        <= HOLD_LEN;
                pix_out_ch.ready <= 1'b0;
            end
            else
            begin
                pix_out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no item moving on either side for too long
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        stall_cycles = 0;
        pix_sent     = 0;
        pix_back     = 0;
        err_count    = 0;
        quiet        = 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;

        // registers after reset
        brush_r   = '0;
        brush_g   = '0;
        brush_b   = '0;
        brush_a   = BRUSH_ALPHA_RST;
        brush_rad = RADIUS_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values read back, then directed pixels against the reset brush
        // (opaque black, radius one pixel)
        for (int i = REG_BRUSH_RED; i <= REG_RADIUS_Q4; i++)
            reg_read_check(REG_IDX_W'(i));
        feed(make_pixel(0, 0, 32'h0000_0000));          // centre, full brush
        feed(make_pixel(0, 0, 32'hFFFF_FFFF));
        feed(make_pixel(16, 0, 32'hFFFF_FFFF));         // exactly on the radius
        feed(make_pixel(20, 0, 32'h8040_20FF));         // quarter pixel into the fringe
        feed(make_pixel(0, -24, 32'hFFFF_FFFF));        // half way
        feed(make_pixel(-28, 0, 32'h1234_5678));
        feed(make_pixel(31, 0, 32'hFFFF_FFFF));         // last sixteenth of the fringe
        feed(make_pixel(32, 0, 32'hA5A5_A5A5));         // fringe ends, zero coverage
        feed(make_pixel(-11, -12, 32'h5A5A_5A5A));
        feed(make_pixel(2047, 2047, 32'hFFFF_FFFF));    // range corners, far outside
        feed(make_pixel(-2048, -2048, 32'h0000_0000));
        feed(make_pixel(2047, -2048, 32'h0F0F_0F0F));
        feed(make_pixel(-2048, 0, 32'hF0F0_F0F0));
        feed(make_pixel(1024, -1024, 32'hFFFF_FFFF));
        feed(make_pixel(0, 1024, 32'h0102_0304));
        run_random(200, 1'b0);

        // radius above the maximum saturates; value bits above each width are dropped
        set_brush(32'hDEAD_BE12, 32'h1234_56F3, 32'hFFFF_FF80, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // writes past the register list change nothing
        for (int i = REG_RADIUS_Q4 + 1; i < 2 ** REG_IDX_W; i++)
            reg_write(REG_IDX_W'(i), $urandom);
        for (int i = REG_BRUSH_RED; i <= REG_RADIUS_Q4; i++)
            reg_read_check(REG_IDX_W'(i));
        feed(make_pixel(1008, 0, 32'h0000_0000));       // on the saturated rim
        feed(make_pixel(0, -1012, 32'hFFFF_FFFF));
        feed(make_pixel(-1023, 0, 32'h7777_7777));
        feed(make_pixel(1024, 0, 32'h8888_8888));       // just outside the fringe
        feed(make_pixel(713, 713, 32'h3C3C_3C3C));
        run_random(220, 1'b0);

        // transparent brush with zero radius: covered pixels are written but unchanged
        set_brush(32'd255, 32'd255, 32'd255, 32'd0, 32'd0);
        feed(make_pixel(0, 0, 32'h1122_3344));
        feed(make_pixel(8, 0, 32'hFFFF_FFFF));
        feed(make_pixel(0, 16, 32'h0000_0000));
        run_random(200, 1'b0);

        // faintest brush: only full coverage gives a nonzero weight
        set_brush(32'd200, 32'd0, 32'd100, 32'd1, 32'd40);
        feed(make_pixel(0, 0, 32'h0000_0000));
        feed(make_pixel(44, 0, 32'hFFFF_FFFF));
        run_random(200, 1'b0);

        // a stretch with no idling at all on either side
        set_brush($urandom, $urandom, $urandom, $urandom, $urandom_range(1023));
        run_random(260, 1'b1);

        // random brushes, one at full opacity
        set_brush($urandom, $urandom, $urandom, 32'd255, $urandom_range(1023));
        run_random(200, 1'b0);
        repeat (3)
        begin
            set_brush($urandom, $urandom, $urandom, $urandom, $urandom_range(1023));
            run_random(200, 1'b0);
        end

        // let any stray item surface before the verdict
        repeat (DRAIN_PAD) @(posedge clk);
        if (blend_due_q.size() != 0)
            flag_mismatch($sformatf("%0d blended pixels never came", blend_due_q.size()));
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
